FILE: rtl/gaussian_blur_3x3_reflect_defines.svh
// Assertion macros shared by the blur RTL.
`ifndef GAUSSIAN_BLUR_3X3_REFLECT_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_REFLECT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define GB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check cons in the cycle after ante.
`define GB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GB_ASSERT_NOW(label, ante, cons, msg)
`define GB_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/gblur_pkg.sv
// Widths, register codes and kernel arithmetic for the 3x3 Gaussian blur.
package gblur_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 16;
	localparam int OCOL_W        = 10;
	localparam int FW_W          = 11;
	localparam int FH_W          = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;
	localparam int HTAP_W        = 10;
	localparam int SUM_W         = 12;
	localparam int DEF_MAX_WIDTH = 1024;

	localparam logic [FW_W-1:0] FW_RESET = 11'd768;
	localparam logic [FH_W-1:0] FH_RESET = 16'd512;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Horizontal 1-2-1 tap over one window row; a is oldest, c newest.
	// At the right edge the missing column mirrors b, at the left edge a mirrors c.
	function automatic logic [HTAP_W-1:0] htap(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] c,
		input logic             left_mirror,
		input logic             right_edge
	);
		logic [HTAP_W-1:0] lhs;
		logic [HTAP_W-1:0] mid2;
		mid2 = {1'b0, b, 1'b0};
		if (right_edge) begin
			htap = mid2 + {1'b0, c, 1'b0};
		end else begin
			lhs  = HTAP_W'(left_mirror ? c : a);
			htap = lhs + mid2 + HTAP_W'(c);
		end
	endfunction

	// Vertical 1-2-1 over three row taps, divided by 16.
	function automatic logic [PIX_W-1:0] vblur(
		input logic [HTAP_W-1:0] top,
		input logic [HTAP_W-1:0] mid,
		input logic [HTAP_W-1:0] bot
	);
		logic [SUM_W-1:0] s;
		s = SUM_W'(top) + {1'b0, mid, 1'b0} + SUM_W'(bot);
		vblur = s[SUM_W-1:4];
	endfunction

endpackage

FILE: rtl/gaussian_blur_3x3_reflect.sv
// Streaming 3x3 Gaussian blur with mirrored borders, one pixel per clock unless stalled.
//
// Pixels enter in raster order and are taken one per clock while in_stall is
// low. Each pixel is registered together with the two line-buffer words of its
// column (the read port of the line memories). Once the four-slot result
// register is free, one pass of adders forms every result the pixel causes into
// it. The result register drains one result per clock while out_stall is low,
// so the rate is set by the output port. From the second row on, the last pixel
// of a row causes two results, a pixel of the last row past its first column
// two, and the last pixel of the frame four; all others cause at most one. A
// pixel's first result is presented from the result register once the pixel
// leaves the input stage. Line buffers come out of reset unwritten and need no
// clearing pass. Width is clamped to 2..MAX_WIDTH, height below 2 is used as 2;
// write the registers only while the block is idle.
`include "gaussian_blur_3x3_reflect_defines.svh"

module gaussian_blur_3x3_reflect
	import gblur_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic [ROW_W-1:0]      out_row,
	output logic [OCOL_W-1:0]     out_col,
	output logic                  run_end,
	output logic                  frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = (FW_W > CW + 1) ? FW_W : CW + 1;
	localparam int NSLOT = 4;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [CW-1:0]    col;
	} slot_t;

	// configuration
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic            wr_width;
	logic            wr_height;
	logic [LW-1:0]   fw_ext;
	logic [LW-1:0]   w_last;
	logic [FH_W-1:0] h_last;

	// counters and handshake
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col;
	logic             last_row;
	logic             in_acc;
	logic             out_acc;
	logic             adv;
	logic             buf_free;

	// line memories
	logic [PIX_W-1:0] line_above     [MAX_WIDTH];
	logic [PIX_W-1:0] line_two_above [MAX_WIDTH];

	// input stage
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] above_s1;
	logic [PIX_W-1:0] two_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             lastc_s1;
	logic             lastr_s1;
	logic [CW-1:0]    wl_s1;

	// window and kernel
	logic [PIX_W-1:0]  win_q  [3][3];
	logic [PIX_W-1:0]  win_nx [3][3];
	logic [HTAP_W-1:0] hn [3];
	logic [HTAP_W-1:0] hr [3];
	logic [HTAP_W-1:0] top_n;
	logic [HTAP_W-1:0] top_r;
	logic              lm;
	logic              top_is_cur;
	logic [NSLOT-1:0]  mask_nx;
	slot_t             slot_nx [NSLOT];

	// result register
	logic [NSLOT-1:0]       slot_vld_q;
	slot_t                  slot_q [NSLOT];
	logic [NSLOT-1:0]       first;
	logic [NSLOT-1:0]       rest;
	logic [$clog2(NSLOT)-1:0] sel;

	assign cfg_ready = 1'b1;

	always_comb begin
		wr_width  = 1'b0;
		wr_height = 1'b0;
		unique case (cfg_reg_t'(cfg_index))
			REG_FRAME_WIDTH:  wr_width  = cfg_valid;
			REG_FRAME_HEIGHT: wr_height = cfg_valid;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else begin
			if (wr_width)
				frame_width_q <= cfg_data[FW_W-1:0];
			if (wr_height)
				frame_height_q <= cfg_data[FH_W-1:0];
		end
	end

	always_comb begin
		fw_ext = LW'(frame_width_q);
		if (fw_ext < LW'(2))
			w_last = LW'(1);
		else if (fw_ext > LW'(MAX_WIDTH))
			w_last = LW'(MAX_WIDTH - 1);
		else
			w_last = fw_ext - LW'(1);
		if (frame_height_q < FH_W'(2))
			h_last = FH_W'(1);
		else
			h_last = frame_height_q - FH_W'(1);
	end

	assign last_col = LW'(col_q) >= w_last;
	assign last_row = row_q >= h_last;

	assign out_valid = |slot_vld_q;
	assign out_acc   = out_valid && !out_stall;
	assign buf_free  = (slot_vld_q == '0) || (out_acc && run_end);
	assign adv       = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	// Read the column on accept, write it back when the item leaves the input stage.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_s1 <= line_above[col_q];
			two_s1   <= line_two_above[col_q];
			pix_s1   <= pixel_in;
			col_s1   <= col_q;
			row_s1   <= row_q;
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
			wl_s1    <= CW'(w_last);
		end
		if (adv) begin
			line_above[col_s1]     <= pix_s1;
			line_two_above[col_s1] <= above_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = two_s1;
		win_nx[1][2] = above_s1;
		win_nx[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win_q[i][j] <= '0;
		end else if (adv) begin
			win_q <= win_nx;
		end
	end

	assign lm         = (col_s1 == CW'(1));
	assign top_is_cur = (row_s1 == ROW_W'(1));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hn[i] = htap(win_nx[i][0], win_nx[i][1], win_nx[i][2], lm, 1'b0);
			hr[i] = htap(win_nx[i][0], win_nx[i][1], win_nx[i][2], 1'b0, 1'b1);
		end
		// On the second row the row above the output mirrors to the current row.
		top_n = top_is_cur ? hn[2] : hn[0];
		top_r = top_is_cur ? hr[2] : hr[0];

		mask_nx[0] = (row_s1 != '0) && (col_s1 != '0);
		mask_nx[1] = mask_nx[0] && lastr_s1;
		mask_nx[2] = (row_s1 != '0) && lastc_s1;
		mask_nx[3] = mask_nx[2] && lastr_s1;

		slot_nx[0].pix = vblur(top_n, hn[1], hn[2]);
		slot_nx[0].row = row_s1 - 1'b1;
		slot_nx[0].col = col_s1 - 1'b1;
		// Last row: the row below mirrors back to the row above.
		slot_nx[1].pix = vblur(hn[1], hn[2], hn[1]);
		slot_nx[1].row = row_s1;
		slot_nx[1].col = col_s1 - 1'b1;
		slot_nx[2].pix = vblur(top_r, hr[1], hr[2]);
		slot_nx[2].row = row_s1 - 1'b1;
		slot_nx[2].col = wl_s1;
		slot_nx[3].pix = vblur(hr[1], hr[2], hr[1]);
		slot_nx[3].row = row_s1;
		slot_nx[3].col = wl_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			slot_q <= slot_nx;
	end

	always_comb begin
		first = slot_vld_q & (~slot_vld_q + 1'b1);
		rest  = slot_vld_q & ~first;
		sel   = '0;
		for (int i = NSLOT - 1; i >= 0; i--)
			if (slot_vld_q[i])
				sel = ($clog2(NSLOT))'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slot_vld_q <= '0;
		else if (adv)
			slot_vld_q <= mask_nx;
		else if (out_acc)
			slot_vld_q <= rest;
	end

	assign pixel_out = slot_q[sel].pix;
	assign out_row   = slot_q[sel].row;
	assign out_col   = OCOL_W'(slot_q[sel].col);
	assign run_end   = (rest == '0);
	assign frame_end = first[NSLOT-1];

	`GB_ASSERT_NOW(a_fend_is_run_end, out_valid && frame_end, run_end, "frame end not last of run")
	`GB_ASSERT_NOW(a_no_overwrite, adv, (slot_vld_q == '0) || (out_acc && run_end), "results overwritten")
	`GB_ASSERT_NXT(a_run_continues, out_acc && !run_end, out_valid, "run lost results")
	`GB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_out) && $stable(out_col), "stalled result changed")

endmodule
